/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the parser design; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property that must hold at every clock edge outside reset
`define ACP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("acp assertion failed");
// expression that must never be true outside reset
`define ACP_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("acp forbidden condition seen");
`else
`define ACP_ASSERT(lbl, clk, rstn, prop)
`define ACP_NEVER(lbl, clk, rstn, expr)
`endif

`endif

/* design/acp_pkg.sv */
// ----------------------------------------------------------------------------
// acp_pkg
// Types, byte codes and defaults for the escape sequence parser.
// ----------------------------------------------------------------------------
package acp_pkg;

  // defaults
  localparam int unsigned MAX_PARAMS_DEF = 8;
  localparam logic [15:0] COLS_RESET     = 16'd80;
  localparam logic [15:0] ROWS_RESET     = 16'd24;
  localparam logic [15:0] VALUE_MAX      = 16'hFFFF;
  localparam logic [15:0] POS_HOME       = 16'd1;

  // byte codes
  localparam logic [7:0] ESC_BYTE  = 8'd27;
  localparam logic [7:0] DEL_BYTE  = 8'd127;
  localparam logic [7:0] PRINT_MIN = 8'd32;
  localparam logic [7:0] CR_BYTE   = 8'h0D;
  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] LBRACKET  = 8'h5B;
  localparam logic [7:0] SEMICOLON = 8'h3B;
  localparam logic [7:0] DIGIT_0   = 8'h30;
  localparam logic [7:0] DIGIT_9   = 8'h39;
  localparam logic [7:0] FINAL_MIN = 8'h40;
  localparam logic [7:0] FINAL_MAX = 8'h7E;

  // config register indexes
  localparam logic CFG_SCREEN_COLUMNS = 1'b0;
  localparam logic CFG_SCREEN_ROWS    = 1'b1;

  // result kinds
  localparam logic KIND_TEXT    = 1'b0;
  localparam logic KIND_CONTROL = 1'b1;

  typedef enum logic [1:0] {
    PH_GROUND = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_CSI    = 2'd2
  } acp_phase_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EMIT = 1'b1
  } acp_state_e;

  // controller to datapath
  typedef struct packed {
    logic take;   // apply the accepted byte
    logic emit;   // load the next control result
  } acp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;   // output register empty or draining
    logic final_hit;  // current byte ends a control sequence
    logic emit_last;  // the next control result is the last one
  } acp_sts_t;

endpackage

/* design/acp_if.sv */
// ----------------------------------------------------------------------------
// acp_in_if / acp_out_if
// Valid/ready channels carrying terminal bytes in and parsed results out.
// ----------------------------------------------------------------------------
interface acp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_chunk;

  modport source (output valid, output data_byte, output last_in_chunk, input ready);
  modport sink   (input valid, input data_byte, input last_in_chunk, output ready);
endinterface

interface acp_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  code_byte;
  logic [3:0]  arg_count;
  logic [2:0]  param_index;
  logic [15:0] param_value;
  logic [15:0] cursor_col;
  logic [15:0] cursor_row;
  logic        last;

  modport source (output valid, output kind, output code_byte, output arg_count,
                  output param_index, output param_value, output cursor_col,
                  output cursor_row, output last, input ready);
  modport sink   (input valid, input kind, input code_byte, input arg_count,
                  input param_index, input param_value, input cursor_col,
                  input cursor_row, input last, output ready);
endinterface

/* design/acp_ctrl.sv */
// ----------------------------------------------------------------------------
// acp_ctrl
// Controller: accepts bytes and sequences the control result burst.
// ----------------------------------------------------------------------------
module acp_ctrl import acp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  acp_sts_t   sts_i,
  output acp_cmd_t   cmd_o,
  output acp_state_e state_o
);

  acp_state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && sts_i.out_free && sts_i.final_hit) state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free && sts_i.emit_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.out_free;
        cmd_o.take = in_valid_i && sts_i.out_free;
      end
      S_EMIT: begin
        cmd_o.emit = sts_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

endmodule

/* design/acp_datapath.sv */
// ----------------------------------------------------------------------------
// acp_datapath
// Parser phase, parameter store, cursor tracking and the output register.
// ----------------------------------------------------------------------------
module acp_datapath import acp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic [7:0]  data_byte_i,
  input  acp_cmd_t    cmd_i,
  output acp_sts_t    sts_o,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic        kind_o,
  output logic [7:0]  code_byte_o,
  output logic [3:0]  arg_count_o,
  output logic [2:0]  param_index_o,
  output logic [15:0] param_value_o,
  output logic [15:0] cursor_col_o,
  output logic [15:0] cursor_row_o,
  output logic        last_o
);

  localparam int unsigned CNT_W = $clog2(MAX_PARAMS + 1);
  localparam int unsigned IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARAMS);

  // config registers
  logic [15:0] cols_q, rows_q;

  // parser state
  acp_phase_e       phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [15:0]      pend_q, pend_d;
  logic             pvalid_q, pvalid_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       final_q, final_d;
  logic [15:0]      col_q, col_d, row_q, row_d;
  logic [15:0]      store_q [MAX_PARAMS];

  // store write port
  logic             st_we;
  logic [15:0]      st_wdata;

  // output register
  logic        ovalid_q, ovalid_d;
  logic        kind_q, kind_d;
  logic [7:0]  code_q, code_d;
  logic [3:0]  pcnt_q, pcnt_d;
  logic [2:0]  pidx_q, pidx_d;
  logic [15:0] pval_q, pval_d;
  logic        last_q, last_d;

  logic             is_final;
  logic [19:0]      digit_acc;
  logic [CNT_W-1:0] idx_next;

  assign is_final  = (data_byte_i >= FINAL_MIN) && (data_byte_i <= FINAL_MAX);
  assign digit_acc = {1'b0, pend_q, 3'b000} + {3'b000, pend_q, 1'b0}
                   + {16'd0, data_byte_i[3:0]};
  assign idx_next  = CNT_W'(idx_q) + CNT_W'(1);

  // status
  assign sts_o.out_free  = !ovalid_q || out_ready_i;
  assign sts_o.final_hit = (phase_q == PH_CSI) && is_final;
  assign sts_o.emit_last = (count_q == '0) || (idx_next == count_q);

  // parser, cursor and result staging
  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    pend_d   = pend_q;
    pvalid_d = pvalid_q;
    idx_d    = idx_q;
    final_d  = final_q;
    col_d    = col_q;
    row_d    = row_q;
    st_we    = 1'b0;
    st_wdata = pvalid_q ? pend_q : 16'd0;
    ovalid_d = ovalid_q && !out_ready_i;
    kind_d   = kind_q;
    code_d   = code_q;
    pcnt_d   = pcnt_q;
    pidx_d   = pidx_q;
    pval_d   = pval_q;
    last_d   = last_q;

    if (cmd_i.take) begin
      case (phase_q)
        PH_ESCAPE: begin
          if (data_byte_i == LBRACKET) begin
            phase_d  = PH_CSI;
            count_d  = '0;
            pend_d   = '0;
            pvalid_d = 1'b0;
          end else begin
            phase_d = PH_GROUND;
          end
        end
        PH_CSI: begin
          if (data_byte_i inside {[DIGIT_0:DIGIT_9]}) begin
            pend_d   = (digit_acc > {4'd0, VALUE_MAX}) ? VALUE_MAX : digit_acc[15:0];
            pvalid_d = 1'b1;
          end else if (data_byte_i == SEMICOLON ||
                       (is_final && (pvalid_q || count_q != '0))) begin
            // close the pending parameter
            if (count_q < CNT_MAX) begin
              st_we   = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
            pend_d   = '0;
            pvalid_d = 1'b0;
          end
          if (is_final) begin
            final_d = data_byte_i;
            idx_d   = '0;
            phase_d = PH_GROUND;
          end
        end
        default: begin
          // ground
          phase_d = PH_GROUND;
          if (data_byte_i == ESC_BYTE) begin
            phase_d = PH_ESCAPE;
          end else begin
            if (data_byte_i == CR_BYTE) begin
              col_d = POS_HOME;
            end else if (data_byte_i == LF_BYTE) begin
              if (row_q < rows_q) row_d = row_q + 16'd1;
            end else if (data_byte_i >= PRINT_MIN && data_byte_i != DEL_BYTE
                         && col_q < cols_q) begin
              col_d = col_q + 16'd1;
            end
            ovalid_d = 1'b1;
            kind_d   = KIND_TEXT;
            code_d   = data_byte_i;
            pcnt_d   = 4'd0;
            pidx_d   = 3'd0;
            pval_d   = 16'd0;
            last_d   = 1'b1;
          end
        end
      endcase
    end

    // one control result per cycle while the output is free, value read from the store when clocked
    if (cmd_i.emit) begin
      ovalid_d = 1'b1;
      kind_d   = KIND_CONTROL;
      code_d   = final_q;
      pcnt_d   = 4'(count_q);
      pidx_d   = 3'(idx_q);
      last_d   = sts_o.emit_last;
      idx_d    = idx_next[IDX_W-1:0];
      if (sts_o.emit_last) begin
        count_d  = '0;
        idx_d    = '0;
        pend_d   = '0;
        pvalid_d = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q   <= COLS_RESET;
      rows_q   <= ROWS_RESET;
      phase_q  <= PH_GROUND;
      count_q  <= '0;
      pend_q   <= '0;
      pvalid_q <= 1'b0;
      idx_q    <= '0;
      col_q    <= POS_HOME;
      row_q    <= POS_HOME;
      ovalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SCREEN_COLUMNS: cols_q <= cfg_wdata_i;
          CFG_SCREEN_ROWS:    rows_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      phase_q  <= phase_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      pvalid_q <= pvalid_d;
      idx_q    <= idx_d;
      col_q    <= col_d;
      row_q    <= row_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers and parameter store
  always_ff @(posedge clk_i) begin
    final_q <= final_d;
    kind_q  <= kind_d;
    code_q  <= code_d;
    pcnt_q  <= pcnt_d;
    pidx_q  <= pidx_d;
    if (cmd_i.emit) begin
      pval_q <= (count_q == '0) ? 16'd0 : store_q[idx_q];
    end else begin
      pval_q <= pval_d;
    end
    last_q  <= last_d;
    if (st_we) store_q[count_q[IDX_W-1:0]] <= st_wdata;
  end

  assign out_valid_o   = ovalid_q;
  assign kind_o        = kind_q;
  assign code_byte_o   = code_q;
  assign arg_count_o   = pcnt_q;
  assign param_index_o = pidx_q;
  assign param_value_o = pval_q;
  assign cursor_col_o  = col_q;
  assign cursor_row_o  = row_q;
  assign last_o        = last_q;

endmodule

/* design/ansi_csi_parser_cursor_unit.sv */
// ----------------------------------------------------------------------------
// ansi_csi_parser_cursor_unit
// Terminal byte parser for CSI escape sequences with cursor tracking.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one terminal byte per item; out_o carries parsed results.
//   a text byte gives one result in the cycle after it is taken, with the
//   cursor position after that byte. ESC, escape bytes, digits, ';' and
//   other bytes inside a sequence give no result.
//   a final byte gives one control result per stored parameter (or one if
//   there are none); it moves the controller to S_EMIT, which loads them
//   into the output register one per cycle while out_o is not stalled, and
//   the input is held off while that burst drains.
//   all results pass through the single output register; a new byte is
//   taken outside a burst when that register is empty or read in that cycle;
//   when out_o stalls the block holds its result and stops taking bytes until
//   the result is read. screen_columns (index 0) and screen_rows (index 1)
//   are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user must
//   do so only while the block is idle; the block itself does not enforce it.
//   reset puts the parser in ground, clears the parameters, homes the cursor
//   to column 1 row 1 and loads limits 80 by 24.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ansi_csi_parser_cursor_unit import acp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  acp_in_if.sink       in_i,
  acp_out_if.source    out_o,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i
);

  acp_cmd_t   cmd;
  acp_sts_t   sts;
  acp_state_e state;

  // controller
  acp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // datapath
  acp_datapath #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .data_byte_i   (in_i.data_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .kind_o        (out_o.kind),
    .code_byte_o   (out_o.code_byte),
    .arg_count_o   (out_o.arg_count),
    .param_index_o (out_o.param_index),
    .param_value_o (out_o.param_value),
    .cursor_col_o  (out_o.cursor_col),
    .cursor_row_o  (out_o.cursor_row),
    .last_o        (out_o.last)
  );

  // checks
  `ACP_NEVER(a_take_and_emit, clk_i, rst_ni, cmd.take && cmd.emit)
  `ACP_ASSERT(a_final_starts_burst, clk_i, rst_ni, (cmd.take && sts.final_hit) |=> (state == S_EMIT))
  `ACP_ASSERT(a_emit_fills_output, clk_i, rst_ni, cmd.emit |=> (out_o.valid && out_o.kind == KIND_CONTROL))
  `ACP_ASSERT(a_text_is_plain, clk_i, rst_ni, (out_o.valid && out_o.kind == KIND_TEXT) |-> (out_o.last && out_o.arg_count == 4'd0 && out_o.param_value == 16'd0))

endmodule

/* verif/tb_acp_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_acp_checker
// Watches the byte and result channels of the escape sequence parser, keeps
// its own copy of the parser state, cursor and screen limits, predicts the
// results of every accepted byte and compares accepted results in order.
// ----------------------------------------------------------------------------
module tb_acp_checker import acp_pkg::*; #(
  parameter int unsigned MAX_PARAMS = MAX_PARAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  acp_in_if           in_i,
  acp_out_if          out_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          control_o
);

  typedef struct packed {
    logic        kind;
    logic [7:0]  code_byte;
    logic [3:0]  arg_count;
    logic [2:0]  param_index;
    logic [15:0] param_value;
    logic [15:0] cursor_col;
    logic [15:0] cursor_row;
    logic        last;
  } parse_result_t;

  // results still owed by the block, oldest first
  parse_result_t result_q[$];

  // predicted parser and cursor state
  acp_phase_e  phase;
  logic [15:0] params [MAX_PARAMS];
  int unsigned n_params;
  int unsigned acc_value;
  logic        acc_valid;
  logic [15:0] col;
  logic [15:0] row;
  logic [15:0] col_limit;
  logic [15:0] row_limit;

  int fails    = 0;
  int checked  = 0;
  int controls = 0;

  assign fail_count_o = fails;
  assign pending_o    = result_q.size();
  assign checked_o    = checked;
  assign control_o    = controls;

  task automatic report_mismatch(input string msg);
    if (fails < 40) $display("%0t ns: result %0d: %s", $time, checked, msg);
    fails++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  task automatic clear_sequence();
    for (int i = 0; i < MAX_PARAMS; i++) params[i] = '0;
    n_params  = 0;
    acc_value = 0;
    acc_valid = 1'b0;
  endtask

  // store the value being built; extra parameters fall on the floor
  task automatic close_param();
    if (n_params < MAX_PARAMS) begin
      params[n_params] = acc_valid ? acc_value[15:0] : '0;
      n_params++;
    end
    acc_value = 0;
    acc_valid = 1'b0;
  endtask

  task automatic push_result(input logic k, input logic [7:0] code,
                             input logic [3:0] cnt, input logic [2:0] idx,
                             input logic [15:0] val, input logic lst);
    parse_result_t r;
    r = '{k, code, cnt, idx, val, col, row, lst};
    result_q.push_back(r);
  endtask

  // advance the parser by one byte and queue whatever it emits
  task automatic predict_byte(input logic [7:0] b);
    int unsigned i;
    case (phase)
      PH_ESCAPE: begin
        if (b == LBRACKET) begin
          phase = PH_CSI;
          clear_sequence();
        end else begin
          phase = PH_GROUND;
        end
      end
      PH_CSI: begin
        if (b >= DIGIT_0 && b <= DIGIT_9) begin
          acc_value = acc_value * 10 + int'(b - DIGIT_0);
          if (acc_value > VALUE_MAX) acc_value = VALUE_MAX;
          acc_valid = 1'b1;
        end else if (b == SEMICOLON) begin
          close_param();
        end else if (b >= FINAL_MIN && b <= FINAL_MAX) begin
          if (acc_valid || n_params != 0) close_param();
          if (n_params == 0) begin
            push_result(KIND_CONTROL, b, 4'd0, 3'd0, 16'd0, 1'b1);
          end else begin
            for (i = 0; i < n_params; i++) begin
              push_result(KIND_CONTROL, b, 4'(n_params), 3'(i), params[i],
                          i + 1 == n_params);
            end
          end
          phase = PH_GROUND;
          clear_sequence();
        end
      end
      default: begin
        phase = PH_GROUND;
        if (b == ESC_BYTE) begin
          phase = PH_ESCAPE;
        end else begin
          if (b == CR_BYTE) begin
            col = POS_HOME;
          end else if (b == LF_BYTE) begin
            if (row < row_limit) row++;
          end else if (b >= PRINT_MIN && b != DEL_BYTE && col < col_limit) begin
            col++;
          end
          push_result(KIND_TEXT, b, 4'd0, 3'd0, 16'd0, 1'b1);
        end
      end
    endcase
  endtask

  task automatic check_result();
    parse_result_t got;
    parse_result_t want;
    got = '{out_i.kind, out_i.code_byte, out_i.arg_count, out_i.param_index,
            out_i.param_value, out_i.cursor_col, out_i.cursor_row, out_i.last};
    checked++;
    if (got.kind === KIND_CONTROL) controls++;
    if (result_q.size() == 0) begin
      report_mismatch("result arrived with nothing expected");
    end else begin
      want = result_q.pop_front();
      check_field("kind", got.kind, want.kind);
      check_field("code_byte", got.code_byte, want.code_byte);
      check_field("arg_count", got.arg_count, want.arg_count);
      check_field("param_index", got.param_index, want.param_index);
      check_field("param_value", got.param_value, want.param_value);
      check_field("cursor_col", got.cursor_col, want.cursor_col);
      check_field("cursor_row", got.cursor_row, want.cursor_row);
      check_field("last", got.last, want.last);
    end
  endtask

  // sample both channels and the register port at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase     = PH_GROUND;
      clear_sequence();
      col       = POS_HOME;
      row       = POS_HOME;
      col_limit = COLS_RESET;
      row_limit = ROWS_RESET;
      result_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SCREEN_COLUMNS) col_limit = cfg_wdata_i;
        else row_limit = cfg_wdata_i;
      end
      if (out_i.valid === 1'b1 && out_i.ready === 1'b1) check_result();
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) predict_byte(in_i.data_byte);
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Byte stream stimulus for the escape sequence parser: directed corner cases,
// then random text and CSI sequences under several screen limits, with random
// idling on both channels except in the last; the checker judges results.
// ----------------------------------------------------------------------------
module tb;
  import acp_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_idx;
  logic [15:0] cfg_wdata;
  bit          idle_on;
  int unsigned bytes_sent;
  int          fail_count;
  int          pending;
  int          checked;
  int          controls;

  acp_in_if  in_ch ();
  acp_out_if out_ch ();

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ansi_csi_parser_cursor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tb_acp_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .control_o    (controls)
  );

  // offer one byte, with an occasional idle burst first, until it is taken
  task automatic send_byte(input logic [7:0] b, input bit counted = 1'b1);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.last_in_chunk <= 1'($urandom_range(0, 1));
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    if (counted) bytes_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold the input until every expected result has come out
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
  endtask

  // a byte that a CSI sequence ignores: not a digit, ';' or final byte
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: b = 8'($urandom_range(0, DIGIT_0 - 1));
      1: begin
        b = 8'($urandom_range(DIGIT_9 + 1, FINAL_MIN - 1));
        if (b == SEMICOLON) b = FINAL_MIN - 1;
      end
      default: b = 8'($urandom_range(FINAL_MAX + 1, 255));
    endcase
    return b;
  endfunction

  // mostly printable, with line controls and the odd arbitrary byte
  function automatic logic [7:0] text_byte();
    case ($urandom_range(0, 7))
      0: return CR_BYTE;
      1: return LF_BYTE;
      2: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(PRINT_MIN, DEL_BYTE - 1));
    endcase
  endfunction

  // well formed CSI sequence with random parameters and stray bytes
  task automatic send_csi();
    int unsigned n_fields;
    int unsigned n_digits;
    int unsigned f;
    int unsigned d;
    send_byte(ESC_BYTE);
    send_byte(LBRACKET);
    n_fields = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 4);
    for (f = 0; f < n_fields; f++) begin
      if (f != 0) send_byte(SEMICOLON);
      n_digits = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
      for (d = 0; d < n_digits; d++) begin
        if ($urandom_range(0, 15) == 0) send_byte(junk_byte(), 1'b0);
        send_byte(8'(DIGIT_0 + $urandom_range(0, 9)));
      end
    end
    if ($urandom_range(0, 7) == 0) send_byte(SEMICOLON);
    send_byte(8'($urandom_range(FINAL_MIN, FINAL_MAX)));
  endtask

  // broken sequence: escape dropped, or CSI with a stray escape inside it
  task automatic send_broken();
    logic [7:0] b;
    send_byte(ESC_BYTE);
    if ($urandom_range(0, 1) == 0) begin
      b = 8'($urandom_range(0, 255));
      if (b == LBRACKET) b = LBRACKET + 1;
      send_byte(b);
    end else begin
      send_byte(LBRACKET);
      send_byte(8'(DIGIT_0 + $urandom_range(0, 9)));
      send_byte(ESC_BYTE, 1'b0);
      send_byte(junk_byte(), 1'b0);
      send_byte(8'($urandom_range(FINAL_MIN, FINAL_MAX)));
    end
  endtask

  task automatic run_random(input int unsigned n_items);
    int unsigned goal;
    goal = bytes_sent + n_items;
    while (bytes_sent < goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: repeat ($urandom_range(1, 6)) send_byte(text_byte());
        4, 5, 6, 7, 8: send_csi();
        default: send_broken();
      endcase
    end
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  // stimulus
  initial begin
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.last_in_chunk = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_SCREEN_COLUMNS;
    cfg_wdata           = '0;
    idle_on             = 1'b1;
    bytes_sent          = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: text extremes, dropped escape, empty and missing parameters,
    // saturation, ignored bytes inside a sequence, too many parameters
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(DEL_BYTE);
    send_byte(CR_BYTE);
    send_byte(LF_BYTE);
    send_string("\033x");
    send_string("\033[;@");
    send_string("\033[70000A");
    send_string("\033[\033!~");
    send_string("\033[;;;;;;;;;m");
    run_random(90);

    // smallest limits: the cursor must hold where it is
    wait_drained();
    write_cfg(CFG_SCREEN_COLUMNS, 16'd1);
    write_cfg(CFG_SCREEN_ROWS, 16'd1);
    run_random(60);

    // largest limits
    wait_drained();
    write_cfg(CFG_SCREEN_COLUMNS, 16'hFFFF);
    write_cfg(CFG_SCREEN_ROWS, 16'hFFFF);
    run_random(60);

    // tiny screen so both limits are hit often
    wait_drained();
    write_cfg(CFG_SCREEN_COLUMNS, 16'd5);
    write_cfg(CFG_SCREEN_ROWS, 16'd3);
    run_random(80);

    wait_drained();
    write_cfg(CFG_SCREEN_COLUMNS, 16'($urandom_range(1, 65535)));
    write_cfg(CFG_SCREEN_ROWS, 16'($urandom_range(1, 65535)));
    run_random(60);

    // back to the reset limits, no idling on either side
    wait_drained();
    idle_on = 1'b0;
    write_cfg(CFG_SCREEN_COLUMNS, COLS_RESET);
    write_cfg(CFG_SCREEN_ROWS, ROWS_RESET);
    run_random(60);

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("sent %0d counted bytes under six screen limit settings", bytes_sent);
    $display("checked %0d results, %0d of them control records", checked, controls);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("TB_ERROR");
    $finish;
  end

endmodule
